// ----- rtl/slt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slt_pkg
// Types and codes shared by the sorted list table and its cells.
// ----------------------------------------------------------------------------
package slt_pkg;

	localparam int VALUE_W = 32;
	localparam int ENTRY_W = 5;

	typedef logic signed [VALUE_W-1:0] value_t;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_DELETE = 2'd1;
	localparam logic [1:0] OP_SEARCH = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_MISSING = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	typedef struct packed {
		logic [1:0] operation;
		value_t     value;
	} slt_cmd_t;

	typedef struct packed {
		logic [1:0]         status;
		value_t             prev_value;
		value_t             next_value;
		logic [ENTRY_W-1:0] entry_count;
	} slt_res_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		logic   ins;
		logic   del;
		value_t value;
	} slt_ctrl_t;

	// per-cell status seen by the neighbors and the controller
	typedef struct packed {
		logic occ;
		logic after;
		logic ge;
		logic first_eq;
	} slt_flags_t;

endpackage

// ----- rtl/slt_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slt_cell
// One slot of the sorted chain: holds a value, compares it with the
// broadcast key and shifts toward either neighbor on insert or delete.
// ----------------------------------------------------------------------------
module slt_cell #(
	parameter int IDX = 0,
	parameter int CW  = 5
) (
	input  logic               clk,
	input  slt_pkg::slt_ctrl_t ctrl,
	input  logic [CW-1:0]      count,
	input  slt_pkg::value_t    left_val,
	input  slt_pkg::slt_flags_t left_flags,
	input  slt_pkg::value_t    right_val,
	output slt_pkg::value_t    val,
	output slt_pkg::slt_flags_t flags
);
	import slt_pkg::*;

	value_t value_q;

	always_comb begin
		flags.occ      = count > CW'(IDX);
		flags.after    = !flags.occ || (value_q > ctrl.value);
		flags.ge       = flags.occ && (value_q >= ctrl.value);
		// sorted: an equal left neighbor is the only way left is ge here
		flags.first_eq = flags.occ && (value_q == ctrl.value) && !left_flags.ge;
	end

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (left_flags.after) begin
				value_q <= left_val;
			end else if (flags.after) begin
				value_q <= ctrl.value;
			end
		end else if (ctrl.del && flags.ge) begin
			value_q <= right_val;
		end
	end

	assign val = value_q;

endmodule

// ----- rtl/sorted_list_table_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_table_unit
// Sorted table of signed values held in a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel (cmd_valid/cmd_ready/cmd_word) carries one operation word:
//   insert, delete or search of a signed 32-bit value.
//   res channel (res_valid/res_ready/res_word) returns exactly one word per
//   command: status, circular predecessor and successor (successful search
//   only, zero otherwise) and the entry count after the operation.
//   The result is registered at the edge that accepts the command. Every
//   cell compares its value with the broadcast key and shifts in the same
//   cycle, so one command per cycle is sustained while results are taken.
//   When the receiver stalls, the result register holds and cmd_ready drops
//   until the word is taken; a new command is accepted in the same cycle the
//   pending result leaves.
//   Reset empties the table (count zero) and drops any pending result word;
//   no clearing pass is needed, so commands are accepted right after reset.
// ----------------------------------------------------------------------------
module sorted_list_table_unit #(
	parameter int CAPACITY = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  slt_pkg::slt_cmd_t cmd_word,
	output logic              res_valid,
	input  logic              res_ready,
	output slt_pkg::slt_res_t res_word
);
	import slt_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);

	logic [CW-1:0] count_q;
	logic [CW-1:0] count_nxt;
	slt_res_t      res_q;
	logic          res_valid_q;

	value_t     ext_val   [CAPACITY+2];
	slt_flags_t ext_flags [CAPACITY+2];

	slt_ctrl_t ctrl;
	logic      cmd_fire;
	logic      full;
	logic      found;
	logic      wrap_next;
	logic      is_last;
	value_t    last_val;
	value_t    prev_acc;
	value_t    next_acc;
	slt_res_t  res_nxt;

	assign cmd_ready = !res_valid_q || res_ready;
	assign cmd_fire  = cmd_valid && cmd_ready;
	assign full      = count_q == CW'(CAPACITY);

	assign ext_val[0]            = '0;
	assign ext_val[CAPACITY+1]   = '0;
	assign ext_flags[0]          = '0;
	assign ext_flags[CAPACITY+1] = '0;

	genvar g;
	generate
		for (g = 0; g < CAPACITY; g++) begin : g_cell
			slt_cell #(
				.IDX (g),
				.CW  (CW)
			) u_cell (
				.clk        (clk),
				.ctrl       (ctrl),
				.count      (count_q),
				.left_val   (ext_val[g]),
				.left_flags (ext_flags[g]),
				.right_val  (ext_val[g+2]),
				.val        (ext_val[g+1]),
				.flags      (ext_flags[g+1])
			);
		end
	endgenerate

	always_comb begin
		found     = 1'b0;
		wrap_next = 1'b0;
		last_val  = '0;
		prev_acc  = '0;
		next_acc  = '0;
		is_last   = 1'b0;
		for (int i = 0; i < CAPACITY; i++) begin
			is_last   = ext_flags[i+1].occ && !ext_flags[i+2].occ;
			found     = found | ext_flags[i+1].first_eq;
			wrap_next = wrap_next | (is_last && ext_flags[i+1].first_eq);
			last_val  = last_val | (is_last ? ext_val[i+1] : '0);
			prev_acc  = prev_acc | (ext_flags[i+2].first_eq ? ext_val[i+1] : '0);
			next_acc  = next_acc |
				((ext_flags[i].first_eq && ext_flags[i+1].occ) ? ext_val[i+1] : '0);
		end
	end

	always_comb begin
		ctrl.value = cmd_word.value;
		ctrl.ins   = cmd_fire && (cmd_word.operation == OP_INSERT) && !full;
		ctrl.del   = cmd_fire && (cmd_word.operation == OP_DELETE) && found;
	end

	always_comb begin
		count_nxt = count_q;
		if (ctrl.ins) begin
			count_nxt = count_q + CW'(1);
		end else if (ctrl.del) begin
			count_nxt = count_q - CW'(1);
		end
	end

	always_comb begin
		res_nxt.status      = ST_MISSING;
		res_nxt.prev_value  = '0;
		res_nxt.next_value  = '0;
		res_nxt.entry_count = ENTRY_W'(count_nxt);
		case (cmd_word.operation)
			OP_INSERT: begin
				res_nxt.status = full ? ST_FULL : ST_OK;
			end
			OP_DELETE: begin
				res_nxt.status = found ? ST_OK : ST_MISSING;
			end
			OP_SEARCH: begin
				if (found) begin
					res_nxt.status     = ST_OK;
					res_nxt.prev_value = prev_acc |
						(ext_flags[1].first_eq ? last_val : '0);
					res_nxt.next_value = next_acc | (wrap_next ? ext_val[1] : '0);
				end
			end
			default: begin
				res_nxt.status = ST_MISSING;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			if (cmd_fire) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			res_q <= res_nxt;
		end
	end

	assign res_valid = res_valid_q;
	assign res_word  = res_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_fire && cmd_word.operation == OP_INSERT && !full)
		|=> count_q == $past(count_q) + CW'(1))
		else $error("insert did not grow the table");

	a_search_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_fire && cmd_word.operation == OP_SEARCH)
		|=> count_q == $past(count_q))
		else $error("search changed the entry count");

	a_full_refused: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_fire && cmd_word.operation == OP_INSERT && full)
		|=> res_word.status == ST_FULL && count_q == CW'(CAPACITY))
		else $error("insert into full table not refused");
`endif

endmodule
